>>> rtl/core/rotating_multilevel_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotating multilevel queue
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ROTATING_MULTILEVEL_QUEUE_MACROS_SVH
`define ROTATING_MULTILEVEL_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotating_multilevel_queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotating_multilevel_queue: next-cycle check failed");

`endif

>>> rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotating multilevel queue package
// Operation codes and fixed field widths of the queue's ports.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned OpWidth    = 2;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned PrioWidth  = 4;
  localparam int unsigned CountWidth = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } op_e;

endpackage

>>> rtl/core/rotating_multilevel_queue.sv
// ----------------------------------------------------------------------------
// Rotating multilevel queue
// LEVELS FIFOs in one shared store, served from a rotating head level.
// ----------------------------------------------------------------------------
// An item is taken in every cycle unless the result register is held by a
// stall, and its result appears in the next cycle. The whole operation (level
// selection, the rotating search for the first non-empty level from the head,
// and the pointer and fill updates) is done in the cycle of acceptance; the
// single-port read of the shared word store is registered and holds the result
// for the output. The store has no reset and needs no clearing pass, so the
// block accepts items as soon as reset is released.
`include "rotating_multilevel_queue_macros.svh"

module rotating_multilevel_queue #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rmq_pkg::OpWidth-1:0]        operation_i,
  input  logic [rmq_pkg::WordWidth-1:0]      data_in_i,
  input  logic [rmq_pkg::PrioWidth-1:0]      priority_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rmq_pkg::WordWidth-1:0]      data_out_o,
  output logic                               data_valid_o,
  output logic                               accepted_o,
  output logic [rmq_pkg::CountWidth-1:0]     total_count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  localparam int unsigned SW   = (DATA_WIDTH < rmq_pkg::WordWidth) ?
                                 DATA_WIDTH : rmq_pkg::WordWidth;
  localparam int unsigned LW   = $clog2(LEVELS);
  localparam int unsigned PW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CAP  = LEVELS * QUEUE_DEPTH;
  localparam int unsigned AW   = $clog2(CAP);
  localparam int unsigned TW   = $clog2(CAP + 1);

  // Shared word store, one QUEUE_DEPTH slice per level.
  logic [SW-1:0] store_mem [CAP];

  logic [PW-1:0] rd_ptr_q [LEVELS];
  logic [PW-1:0] rd_ptr_d [LEVELS];
  logic [PW-1:0] wr_ptr_q [LEVELS];
  logic [PW-1:0] wr_ptr_d [LEVELS];
  logic [FW-1:0] fill_q   [LEVELS];
  logic [FW-1:0] fill_d   [LEVELS];
  logic [LW-1:0] head_q, head_d;
  logic [TW-1:0] total_q, total_d;

  logic          out_valid_q;
  logic          dv_q, dv_d;
  logic          acc_q, acc_d;
  logic [SW-1:0] rdata_q;

  logic          in_accept;
  rmq_pkg::op_e  op;
  logic [LW-1:0] prio_clamped;
  logic [LW:0]   enq_sum;
  logic [LW-1:0] enq_level;
  logic [LW-1:0] sel_level;
  logic          any_held;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          pop_en;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign op         = rmq_pkg::op_e'(operation_i);
  assign any_held   = (total_q != '0);

  // Enqueue level: offset (LEVELS-1 - priority) from the head, modulo LEVELS.
  always_comb begin
    if (32'(priority_req_i) > (LEVELS - 1)) begin
      prio_clamped = LW'(LEVELS - 1);
    end else begin
      prio_clamped = LW'(priority_req_i);
    end
    enq_sum = (LW + 1)'(head_q) + (LW + 1)'(LEVELS - 1) - (LW + 1)'(prio_clamped);
    if (enq_sum >= (LW + 1)'(LEVELS)) begin
      enq_sum = enq_sum - (LW + 1)'(LEVELS);
    end
    enq_level = enq_sum[LW-1:0];
  end

  // Rotating find-first over the non-empty flags, starting at the head.
  always_comb begin
    logic [LW:0] idx;
    logic        found;
    found     = 1'b0;
    sel_level = head_q;
    for (int i = 0; i < LEVELS; i++) begin
      idx = (LW + 1)'(head_q) + (LW + 1)'(i);
      if (idx >= (LW + 1)'(LEVELS)) begin
        idx = idx - (LW + 1)'(LEVELS);
      end
      if (!found && fill_q[idx[LW-1:0]] != '0) begin
        found     = 1'b1;
        sel_level = idx[LW-1:0];
      end
    end
  end

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    head_d   = head_q;
    total_d  = total_q;
    dv_d     = 1'b0;
    acc_d    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    pop_en   = 1'b0;
    wr_addr  = AW'(32'(enq_level) * QUEUE_DEPTH + 32'(wr_ptr_q[enq_level]));
    rd_addr  = AW'(32'(sel_level) * QUEUE_DEPTH + 32'(rd_ptr_q[sel_level]));
    if (in_accept) begin
      unique case (op)
        rmq_pkg::OP_ENQUEUE: begin
          if (fill_q[enq_level] != FW'(QUEUE_DEPTH)) begin
            wr_en = 1'b1;
            acc_d = 1'b1;
            if (wr_ptr_q[enq_level] == PW'(QUEUE_DEPTH - 1)) begin
              wr_ptr_d[enq_level] = '0;
            end else begin
              wr_ptr_d[enq_level] = wr_ptr_q[enq_level] + 1'b1;
            end
            fill_d[enq_level] = fill_q[enq_level] + 1'b1;
            total_d           = total_q + 1'b1;
          end
        end
        rmq_pkg::OP_DEQUEUE, rmq_pkg::OP_PEEK: begin
          if (any_held) begin
            rd_en  = 1'b1;
            dv_d   = 1'b1;
            head_d = sel_level;
            pop_en = (op == rmq_pkg::OP_DEQUEUE);
          end
        end
        default: begin
        end
      endcase
      if (pop_en) begin
        if (rd_ptr_q[sel_level] == PW'(QUEUE_DEPTH - 1)) begin
          rd_ptr_d[sel_level] = '0;
        end else begin
          rd_ptr_d[sel_level] = rd_ptr_q[sel_level] + 1'b1;
        end
        fill_d[sel_level] = fill_q[sel_level] - 1'b1;
        total_d           = total_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= data_in_i[SW-1:0];
    end
    if (rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        fill_q[i]   <= '0;
      end
      head_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      acc_q       <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      head_q   <= head_d;
      total_q  <= total_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
        dv_q        <= dv_d;
        acc_q       <= acc_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status reflects the state after the item held in the result register,
  // since nothing further is accepted while that result waits.
  assign out_valid_o   = out_valid_q;
  assign data_valid_o  = dv_q;
  assign accepted_o    = acc_q;
  assign data_out_o    = dv_q ? rmq_pkg::WordWidth'(rdata_q) : '0;
  assign total_count_o = rmq_pkg::CountWidth'(total_q);
  assign is_empty_o    = (total_q == '0);
  assign is_full_o     = (total_q == TW'(CAP));

  `RMQ_ASSERT_NEXT(a_enq_counts_up, clk_i, rst_ni, wr_en, total_q == $past(total_q) + 1'b1)
  `RMQ_ASSERT_NEXT(a_pop_counts_down, clk_i, rst_ni, pop_en, total_q == $past(total_q) - 1'b1)
  `RMQ_ASSERT_NEXT(a_head_still, clk_i, rst_ni, !rd_en, head_q == $past(head_q))
  `RMQ_ASSERT_IMP(a_read_held_level, clk_i, rst_ni, rd_en, fill_q[sel_level] != '0)

endmodule
